// ===== rtl/aigtt_pkg.sv =====
`default_nettype none
package aigtt_pkg;

  localparam int MAX_NODES  = 4096;
  localparam int MAX_INPUTS = 12;
  localparam int MAX_WORDS  = 64;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int WIDX_W  = $clog2(MAX_WORDS);
  localparam int NIN_W   = 4;
  localparam int TADDR_W = NODE_W + WIDX_W;
  localparam int TDEPTH  = MAX_NODES * MAX_WORDS;

  localparam logic [63:0] ALL_ONES = '1;

  localparam logic [63:0] PROJ6 [6] = '{
    64'hAAAAAAAAAAAAAAAA, 64'hCCCCCCCCCCCCCCCC, 64'hF0F0F0F0F0F0F0F0,
    64'hFF00FF00FF00FF00, 64'hFFFF0000FFFF0000, 64'hFFFFFFFF00000000
  };

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_FANIN = 2'd1,
    REQ_CONST = 2'd2,
    REQ_READ  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INIT,
    BK_CONST,
    BK_FANIN,
    BK_READ,
    BK_DRAIN
  } bk_state_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  src;
    logic               inv;
    logic               first;
    logic               last;
    logic               writable;
  } cmd_t;

  function automatic logic [NIN_W-1:0] eff_inputs(input logic [NIN_W-1:0] n);
    if (n > NIN_W'(MAX_INPUTS)) begin
      return NIN_W'(MAX_INPUTS);
    end
    return n;
  endfunction

  function automatic logic [WIDX_W-1:0] last_word_idx(input logic [NIN_W-1:0] n);
    logic [10:0] w;
    w = (n <= NIN_W'(6)) ? 11'd1 : (11'd1 << (n - NIN_W'(6)));
    if (w > 11'(MAX_WORDS)) begin
      w = 11'(MAX_WORDS);
    end
    return WIDX_W'(w - 11'd1);
  endfunction

  function automatic logic [63:0] tail_mask(input logic [NIN_W-1:0] n);
    logic [63:0] m;
    if (n >= NIN_W'(6)) begin
      m = ALL_ONES;
    end else begin
      m = (64'd1 << (7'd1 << n)) - 64'd1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aigtt_ram.sv =====
`default_nettype none
module aigtt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aigtt_front.sv =====
`default_nettype none
module aigtt_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [aigtt_pkg::NIN_W-1:0]    eff_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [31:0]                    in_tdata,
  input  wire logic [2:0]                     in_tuser,
  input  wire logic                           in_tlast,
  output      logic                           q_valid,
  output      aigtt_pkg::cmd_t                q_cmd,
  input  wire logic                           q_pop
);
  import aigtt_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push;
  logic [NODE_W-1:0] node;
  logic [12:0]       lit;

  assign node = in_tdata[11:0];
  assign lit  = in_tdata[24:12];

  always_comb begin
    cmd.kind     = req_kind_t'(in_tuser[1:0]);
    cmd.node     = node;
    cmd.src      = lit[12:1];
    cmd.inv      = lit[0];
    cmd.first    = in_tuser[2];
    cmd.last     = in_tlast;
    cmd.writable = node > NODE_W'(eff_n);
  end

  assign in_tready = cnt_r != 2'd2;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = cnt_r != 2'd0;
  assign q_cmd     = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aigtt_back.sv =====
`default_nettype none
module aigtt_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [aigtt_pkg::NIN_W-1:0]   eff_n,
  input  wire logic [aigtt_pkg::WIDX_W-1:0]  nw_m1,
  input  wire logic [63:0]                   mask,
  input  wire logic                          q_valid,
  input  wire aigtt_pkg::cmd_t               q_cmd,
  output      logic                          q_pop,
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  output      logic [71:0]                   out_tdata,
  output      logic                          out_tlast
);
  import aigtt_pkg::*;

  bk_state_t state_r, state_nxt;
  cmd_t      cmd_r;
  logic [WIDX_W-1:0] w_r;
  logic [NIN_W-1:0]  p_r;
  logic              s2_valid_r, s2_accv_r;
  logic [WIDX_W-1:0] s2_w_r;
  logic [MAX_WORDS-1:0] accv_r;
  logic              out_valid_r, out_last_r;
  logic [WIDX_W-1:0] out_idx_r;
  logic [63:0]       out_word_r;

  logic out_free, s2_read, s2_free, issue, w_end;
  logic t_we, a_we, clr_acc;
  logic [TADDR_W-1:0] t_waddr;
  logic [63:0] t_wdata, t_rdata, a_rdata, f_val, r_val, init_val;
  logic [NIN_W-1:0] pm1;

  assign out_free = !out_valid_r || out_tready;
  assign s2_read  = cmd_r.kind == REQ_READ;
  assign s2_free  = !s2_valid_r || !s2_read || out_free;
  assign issue    = (state_r == BK_FANIN || state_r == BK_READ) && s2_free;
  assign w_end    = w_r == nw_m1;
  assign q_pop    = state_r == BK_IDLE && q_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            REQ_INIT:  state_nxt = BK_INIT;
            REQ_FANIN: state_nxt = BK_FANIN;
            REQ_CONST: state_nxt = BK_CONST;
            REQ_READ:  state_nxt = BK_READ;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_INIT:  if (w_end && p_r == eff_n) state_nxt = BK_IDLE;
      BK_CONST: if (!cmd_r.writable || w_end) state_nxt = BK_IDLE;
      BK_FANIN, BK_READ: if (issue && w_end) state_nxt = BK_DRAIN;
      BK_DRAIN: if (s2_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  assign pm1 = p_r - NIN_W'(1);

  always_comb begin
    if (p_r == '0) begin
      init_val = '0;
    end else if (pm1 < NIN_W'(6)) begin
      init_val = PROJ6[pm1[2:0]];
    end else begin
      init_val = w_r[3'(pm1 - NIN_W'(6))] ? ALL_ONES : '0;
    end
    if (w_end) begin
      init_val = init_val & mask;
    end
  end

  always_comb begin
    f_val = (s2_accv_r ? a_rdata : ALL_ONES) & (t_rdata ^ {64{cmd_r.inv}});
    r_val = t_rdata ^ {64{cmd_r.inv}};
    if (s2_w_r == nw_m1) begin
      r_val = r_val & mask;
    end
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = {cmd_r.node, w_r};
    t_wdata = init_val;
    a_we    = 1'b0;
    clr_acc = 1'b0;
    unique case (state_r)
      BK_IDLE: clr_acc = q_pop && q_cmd.kind == REQ_FANIN && q_cmd.first;
      BK_INIT: begin
        t_we    = 1'b1;
        t_waddr = {NODE_W'(p_r), w_r};
      end
      BK_CONST: begin
        t_we    = cmd_r.writable;
        t_wdata = w_end ? mask : ALL_ONES;
      end
      BK_DRAIN: clr_acc = s2_free && cmd_r.kind == REQ_FANIN && cmd_r.last;
      default: ;
    endcase
    if (s2_valid_r && cmd_r.kind == REQ_FANIN) begin
      if (cmd_r.last) begin
        t_we    = cmd_r.writable;
        t_waddr = {cmd_r.node, s2_w_r};
        t_wdata = (s2_w_r == nw_m1) ? (f_val & mask) : f_val;
      end else begin
        a_we = 1'b1;
      end
    end
  end

  aigtt_ram #(.WIDTH(64), .DEPTH(TDEPTH)) u_tbl (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(issue), .raddr({cmd_r.src, w_r}), .rdata(t_rdata)
  );

  aigtt_ram #(.WIDTH(64), .DEPTH(MAX_WORDS)) u_acc (
    .clk(clk), .we(a_we), .waddr(s2_w_r), .wdata(f_val),
    .re(issue), .raddr(w_r), .rdata(a_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (issue) begin
      s2_w_r    <= w_r;
      s2_accv_r <= accv_r[w_r];
    end
    if (s2_valid_r && s2_read && out_free) begin
      out_idx_r  <= s2_w_r;
      out_word_r <= r_val;
      out_last_r <= s2_w_r == nw_m1;
    end
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      w_r         <= '0;
      p_r         <= '0;
      s2_valid_r  <= 1'b0;
      accv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        w_r <= '0;
        p_r <= '0;
      end else if (issue || state_r == BK_CONST || state_r == BK_INIT) begin
        w_r <= w_end ? '0 : w_r + WIDX_W'(1);
        if (state_r == BK_INIT && w_end) begin
          p_r <= p_r + NIN_W'(1);
        end
      end
      if (issue) begin
        s2_valid_r <= 1'b1;
      end else if (s2_free) begin
        s2_valid_r <= 1'b0;
      end
      if (clr_acc) begin
        accv_r <= '0;
      end else if (a_we) begin
        accv_r[s2_w_r] <= 1'b1;
      end
      if (s2_valid_r && s2_read && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_word_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/aig_truth_table_simulator_core.sv =====
// channel | dir | handshake           | payload
// in      | in  | in_tvalid/in_tready | tdata node_id, literal; tuser req_type, first_fanin;
//         |     |                     | tlast last_fanin
// out     | out | out_tvalid/out_tready | tdata word_index, table_word; tlast last_word
// cfg     | in  | cfg_valid/cfg_ready | cfg_data num_inputs
// Fanin and read items take one table word per cycle (1 to 64 words, from num_inputs), a read
// only while the output is not stalled; a constant item writes its words at the same rate, or
// none when its node is not writable. Init writes a zero table and one projection table for
// each of n inputs, n being num_inputs capped at 12.
// Items pass through a two-entry queue, so input is taken while the engine works and the queue has room.
// Output backpressure stalls read issue word by word. Synchronous active-low reset.
`default_nettype none
module aig_truth_table_simulator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // node_id[11:0], literal[24:12]
  input  wire logic [2:0]  in_tuser,   // req_type[1:0], first_fanin[2]
  input  wire logic        in_tlast,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [71:0] out_tdata,  // word_index[5:0], table_word[69:6]
  output      logic        out_tlast,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [3:0]  cfg_data
);
  import aigtt_pkg::*;

  logic [NIN_W-1:0]  num_inputs_r, eff_n;
  logic [WIDX_W-1:0] nw_m1;
  logic [63:0]       mask;
  logic              q_valid, q_pop;
  cmd_t              q_cmd;

  assign cfg_ready = 1'b1;
  assign eff_n     = eff_inputs(num_inputs_r);
  assign nw_m1     = last_word_idx(eff_n);
  assign mask      = tail_mask(eff_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inputs_r <= '0;
    end else if (cfg_valid) begin
      num_inputs_r <= cfg_data;
    end
  end

  aigtt_front u_front (
    .clk(clk), .rst_n(rst_n), .eff_n(eff_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  aigtt_back u_back (
    .clk(clk), .rst_n(rst_n), .eff_n(eff_n), .nw_m1(nw_m1), .mask(mask),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] <= nw_m1)
    else $error("word index past table end");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[5:0] == nw_m1)))
    else $error("last word flag mismatch");

  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tdata[69:6] & ~mask) == '0)
    else $error("tail bits not masked");

endmodule
`default_nettype wire

// ===== dv/tb_aig_truth_table_simulator_core.sv =====
`default_nettype none
module tb_aig_truth_table_simulator_core;
  import aigtt_pkg::*;

  typedef struct {
    req_kind_t   kind;
    logic [11:0] node;
    logic [12:0] lit;
    logic        first;
    logic        last;
  } req_t;

  typedef struct {
    logic [5:0]  idx;
    logic [63:0] word;
    logic        lastw;
  } word_exp_t;

  class TableScoreboard;
    logic [63:0] tbl[int];
    logic [63:0] acc[MAX_WORDS];
    int unsigned nin;
    int          built[$];
    word_exp_t   expq[$];
    int          errors;
    int          reads;
    int          words;

    function new();
      foreach (acc[i]) acc[i] = '1;
      nin = 0;
      errors = 0;
      reads = 0;
      words = 0;
    endfunction

    function int unsigned eff();
      return (nin > MAX_INPUTS) ? MAX_INPUTS : nin;
    endfunction

    function int unsigned nwords();
      int unsigned w;
      w = (eff() <= 6) ? 1 : (1 << (eff() - 6));
      return (w > MAX_WORDS) ? MAX_WORDS : w;
    endfunction

    function logic [63:0] tmask();
      if (eff() >= 6) return '1;
      return (64'd1 << (1 << eff())) - 64'd1;
    endfunction

    function logic [63:0] rd(int node, int w);
      if (tbl.exists(node * MAX_WORDS + w)) return tbl[node * MAX_WORDS + w];
      return 64'd0;
    endfunction

    function bit readable(int node);
      for (int w = 0; w < nwords(); w++) begin
        if (!tbl.exists(node * MAX_WORDS + w)) return 0;
      end
      return 1;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function void report(string s);
      $display("mismatch: %s", s);
      errors++;
    endfunction

    function void note(req_t r);
      int unsigned nw;
      int          src;
      logic [63:0] inv;
      logic [63:0] v;
      word_exp_t   e;
      bit          wr;
      nw = nwords();
      src = r.lit >> 1;
      inv = r.lit[0] ? '1 : '0;
      wr = (r.node > eff());
      case (r.kind)
        REQ_INIT: begin
          for (int p = 0; p <= eff(); p++) begin
            for (int w = 0; w < nw; w++) begin
              if (p == 0) v = '0;
              else if (p <= 6) v = PROJ6[p-1];
              else v = (w & (1 << (p - 7))) ? '1 : '0;
              if (w == nw - 1) v &= tmask();
              tbl[p * MAX_WORDS + w] = v;
            end
            built.insert(built.size(), p);
          end
        end
        REQ_FANIN: begin
          if (r.first) foreach (acc[i]) acc[i] = '1;
          for (int w = 0; w < nw; w++) acc[w] &= rd(src, w) ^ inv;
          if (r.last) begin
            if (wr) begin
              for (int w = 0; w < nw; w++)
                tbl[r.node * MAX_WORDS + w] = (w == nw - 1) ? (acc[w] & tmask()) : acc[w];
              built.insert(built.size(), r.node);
            end
            foreach (acc[i]) acc[i] = '1;
          end
        end
        REQ_CONST: begin
          if (wr) begin
            for (int w = 0; w < nw; w++)
              tbl[r.node * MAX_WORDS + w] = (w == nw - 1) ? tmask() : '1;
            built.insert(built.size(), r.node);
          end
        end
        default: begin
          reads++;
          for (int w = 0; w < nw; w++) begin
            e.idx = w[5:0];
            e.word = rd(src, w) ^ inv;
            if (w == nw - 1) e.word &= tmask();
            e.lastw = (w == nw - 1);
            expq.insert(expq.size(), e);
          end
        end
      endcase
    endfunction

    function void check(logic [71:0] d, logic l);
      word_exp_t e;
      words++;
      if (expq.size() == 0) begin
        report($sformatf("unexpected word idx=%0d", d[5:0]));
        return;
      end
      e = expq.pop_front();
      if (d[5:0] !== e.idx)
        report($sformatf("word_index got %0d exp %0d", d[5:0], e.idx));
      if (d[69:6] !== e.word)
        report($sformatf("table_word idx=%0d got %h exp %h", e.idx, d[69:6], e.word));
      if (l !== e.lastw)
        report($sformatf("last_word idx=%0d got %b exp %b", e.idx, l, e.lastw));
    endfunction
  endclass

  localparam int LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  TableScoreboard sb;
  int  cycles;
  bit  quiet;
  bit  hold_go;
  int  sent;

  aig_truth_table_simulator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    req_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        r.kind = req_kind_t'(in_tuser[1:0]);
        r.first = in_tuser[2];
        r.node = in_tdata[11:0];
        r.lit = in_tdata[24:12];
        r.last = in_tlast;
        sb.note(r);
      end
      if (out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
      if (cfg_valid && cfg_ready) sb.nin = cfg_data;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        out_tready <= 1'b0;
        repeat (399) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send(req_t r);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, r.lit, r.node};
    in_tuser <= {r.first, r.kind};
    in_tlast <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_inputs(logic [3:0] n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t mk(req_kind_t k, int node, int lit, bit f, bit l);
    req_t r;
    r.kind = k;
    r.node = node[11:0];
    r.lit = lit[12:0];
    r.first = f;
    r.last = l;
    return r;
  endfunction

  function automatic int pick_lit();
    int node;
    repeat (8) begin
      node = sb.built[$urandom_range(0, sb.built.size() - 1)];
      if (sb.readable(node)) return node * 2 + $urandom_range(0, 1);
    end
    return $urandom_range(0, 1);
  endfunction

  task automatic random_items(int count);
    int k;
    int len;
    k = 0;
    while (k < count) begin
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            send(mk(REQ_FANIN, $urandom_range(0, 4095), pick_lit(), i == 0, i == len - 1));
          k += len;
        end
        [55:69]: begin
          send(mk(REQ_CONST, $urandom_range(0, 4095), $urandom_range(0, 8191),
                  $urandom_range(0, 1), $urandom_range(0, 1)));
          k++;
        end
        [70:91]: begin
          send(mk(REQ_READ, $urandom_range(0, 4095), pick_lit(),
                  $urandom_range(0, 1), $urandom_range(0, 1)));
          k++;
        end
        [92:96]: begin
          send(mk(REQ_FANIN, $urandom_range(0, 4095), pick_lit(),
                  $urandom_range(0, 1), $urandom_range(0, 1)));
          k++;
        end
        default: begin
          send(mk(REQ_INIT, $urandom_range(0, 4095), $urandom_range(0, 8191),
                  $urandom_range(0, 1), $urandom_range(0, 1)));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    logic [3:0] nset [9];
    int         cnt  [9];
    sb = new();
    cycles = 0;
    quiet = 0;
    hold_go = 0;
    sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    nset = '{4'd0, 4'd12, 4'd5, 4'd15, 4'd7, 4'd1, 4'd6, 4'd2, 4'd4};
    cnt = '{25, 12, 45, 10, 30, 40, 40, 40, 45};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_inputs(4'd3);
    send(mk(REQ_INIT, 0, 0, 0, 0));
    send(mk(REQ_READ, 0, 0, 0, 0));
    send(mk(REQ_READ, 4095, 1, 1, 1));
    for (int l = 2; l < 8; l++) send(mk(REQ_READ, 0, l, 0, 1));
    send(mk(REQ_CONST, 4095, 0, 0, 0));
    send(mk(REQ_READ, 0, 8190, 0, 0));
    send(mk(REQ_READ, 0, 8191, 0, 0));
    send(mk(REQ_FANIN, 0, 2, 1, 1));
    send(mk(REQ_FANIN, 10, 2, 1, 0));
    send(mk(REQ_FANIN, 10, 5, 0, 0));
    send(mk(REQ_FANIN, 10, 7, 0, 1));
    send(mk(REQ_READ, 0, 20, 0, 0));
    send(mk(REQ_READ, 0, 21, 0, 0));
    send(mk(REQ_FANIN, 3, 8191, 1, 1));
    send(mk(REQ_CONST, 2, 0, 1, 1));
    send(mk(REQ_READ, 0, 6, 0, 0));
    send(mk(REQ_READ, 0, 4, 0, 0));
    send(mk(REQ_FANIN, 11, 21, 0, 0));
    send(mk(REQ_FANIN, 11, 4, 0, 1));
    send(mk(REQ_READ, 0, 22, 0, 0));
    send(mk(REQ_READ, 0, 23, 0, 0));
    drop_valid();
    settle();

    for (int p = 0; p < 9; p++) begin
      write_inputs(nset[p]);
      if (p == 8) quiet = 1;
      if (p == 2) hold_go = 1;
      send(mk(REQ_INIT, $urandom_range(0, 4095), 0, 0, 0));
      random_items(cnt[p] / 2);
      if (p == 6) begin
        drop_valid();
        while (sb.pending() > 0) @(posedge clk);
      end
      random_items(cnt[p] - cnt[p] / 2);
      drop_valid();
      settle();
    end

    $display("run: %0d items sent, %0d reads, %0d table words checked", sent, sb.reads,
             sb.words);
    $display("input counts 0..15 with init, fanin chains, constants and long stalls");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
